>>> hw/rtl/tdp_pkg.sv
// shared types and constants for the trial division prime test unit
package tdp_pkg;

   // first trial divisor
   localparam int unsigned FIRST_DIVISOR = 2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_WAIT,
      S_RESULT
   } tdp_state_type;

   typedef struct packed {
      logic start;
   } tdp_div_ctrl_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } tdp_div_status_type;

endpackage

>>> hw/rtl/trial_division_prime_test_unit.sv
// top level: sequencer driving the single divider for trial division
//
// Each beat on req_ carries one candidate; one beat on rsp_ answers whether it is
// prime (0 and 1 are reported as not prime). Divisors 2, 3, 4, ... are tried in
// turn on a single bit-serial divider; each divisor goes through a load,
// CANDIDATE_BITS shift/subtract steps and a check. The test stops at the first
// divisor that divides the candidate or once the divisor exceeds the quotient;
// candidates below 2 skip the divider and go straight to the result. req_ready is
// high only while no candidate is under test or waiting for the rsp_ register; a
// finished answer waits in the rsp_ output register without holding up the next
// request.
module trial_division_prime_test_unit import tdp_pkg::*; #(
   parameter int unsigned CANDIDATE_BITS = 31
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CANDIDATE_BITS-1:0] req_candidate,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_prime
);

   localparam logic [CANDIDATE_BITS-1:0] FIRST_D = CANDIDATE_BITS'(FIRST_DIVISOR);

   tdp_state_type             state_ff, state_in;
   logic [CANDIDATE_BITS-1:0] cand_ff, cand_in;
   logic [CANDIDATE_BITS-1:0] div_ff, div_in;
   logic                      verdict_ff, verdict_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_prime_ff, rsp_prime_in;
   logic                      req_beat;
   logic                      slot_free;
   tdp_div_ctrl_type          div_ctrl;
   tdp_div_status_type        div_status;
   logic [CANDIDATE_BITS-1:0] quotient;

   tdp_divider #(
      .WIDTH(CANDIDATE_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .dividend(cand_ff),
      .divisor (div_ff),
      .status  (div_status),
      .quotient(quotient)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = (req_candidate < FIRST_D) ? S_RESULT : S_START;
            end
         end
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (div_status.done) begin
               if (quotient < div_ff || div_status.rem_zero) begin
                  state_in = S_RESULT;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cand_in        = cand_ff;
      div_in         = div_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_prime_in   = rsp_prime_ff;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               cand_in    = req_candidate;
               div_in     = FIRST_D;
               verdict_in = 1'b0;
            end
         end
         S_START: div_ctrl.start = 1'b1;
         S_WAIT: begin
            if (div_status.done) begin
               // divisor past the square bound means no factor exists
               if (quotient < div_ff) begin
                  verdict_in = 1'b1;
               end else if (div_status.rem_zero) begin
                  verdict_in = 1'b0;
               end else begin
                  div_in = div_ff + 1'b1;
               end
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff      <= cand_in;
      div_ff       <= div_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

endmodule

>>> hw/rtl/tdp_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module tdp_divider import tdp_pkg::*; #(
   parameter int unsigned WIDTH = 31
) (
   input  logic               clock,
   input  logic               reset,
   input  tdp_div_ctrl_type   ctrl,
   input  logic [WIDTH-1:0]   dividend,
   input  logic [WIDTH-1:0]   divisor,
   output tdp_div_status_type status,
   output logic [WIDTH-1:0]   quotient
);

   localparam int unsigned COUNT_BITS = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]      quo_ff, quo_in;
   logic [WIDTH-1:0]      dsr_ff, dsr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  done_ff, done_in;
   logic [WIDTH:0]        shifted;
   logic [WIDTH:0]        diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
         count_in = COUNT_BITS'(WIDTH);
      end else if (count_ff != '0) begin
         // restore when the trial subtract goes negative
         if (diff[WIDTH]) begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);
   assign quotient        = quo_ff;

endmodule
